// File: rtl/log_replay_last_op_table_assert.svh
// assertion macros for the last-op table
`ifndef LOG_REPLAY_LAST_OP_TABLE_ASSERT_SVH
`define LOG_REPLAY_LAST_OP_TABLE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lrt_pkg.sv
`timescale 1ns / 1ps
package lrt_pkg;
  localparam int unsigned SlotCountDef = 4096;
  localparam logic [31:0] HashMult = 32'd2654435761;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_MARKER  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_DRAINED = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  localparam logic [1:0] OP_MARKER = 2'd0;
  localparam logic       FN_DRAIN  = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot_index;
    logic [15:0] out_type;
    logic [31:0] out_id;
    logic [1:0]  out_op;
    logic [31:0] out_len;
  } lrt_result_t;

  typedef struct packed {
    logic        func;
    logic [1:0]  op_code;
    logic [15:0] rec_type;
    logic [31:0] obj_id;
    logic [31:0] payload_len;
  } lrt_request_t;
endpackage

// File: rtl/lrt_if.sv
`timescale 1ns / 1ps
interface lrt_req_if import lrt_pkg::*; ();
  logic         valid;
  logic         ready;
  lrt_request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrt_res_if import lrt_pkg::*; ();
  logic        valid;
  logic        ready;
  lrt_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lrt_slot_mem.sv
`timescale 1ns / 1ps
// slot payload memory and epoch-tagged valid memory, registered read
module lrt_slot_mem import lrt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDef,
  parameter int unsigned AW = $clog2(SLOT_COUNT)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_used,
  output logic [81:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [81:0]   wr_data,
  input  logic          cur_epoch,
  input  logic          epoch_wr_en,
  input  logic [AW-1:0] epoch_wr_addr,
  input  logic          epoch_wr_val
);
  logic [81:0] data_mem [SLOT_COUNT];
  logic [1:0]  tag_mem [SLOT_COUNT];
  logic [1:0]  tag_q;

  // payload: type, id, op, len
  always_ff @(posedge clk) begin
    if (wr_en) data_mem[wr_addr] <= wr_data;
    rd_data <= data_mem[rd_addr];
  end

  // tag {written, epoch}: slot is used when written in the current epoch
  always_ff @(posedge clk) begin
    if (epoch_wr_en) tag_mem[epoch_wr_addr] <= {1'b1, epoch_wr_val};
    tag_q <= tag_mem[rd_addr];
  end

  assign rd_used = tag_q[1] && (tag_q[0] == cur_epoch);
endmodule

// File: rtl/log_replay_last_op_table.sv
`timescale 1ns / 1ps
// Log-compaction table over (type, id) keys with linear probing; SLOT_COUNT
// must be a power of two. One request at a time: a record passes the accept
// state, a hash state, a read and a check state per probed slot (every slot
// when the table is full) and the result state, a marker only the accept and
// result states; a drain passes the accept state, a read and an inspect phase
// per scanned slot and the result state. Both are bound by the single read
// port of the slot memory, and a stalled result holds the block. After reset
// a clearing pass writes every tag entry while no request is taken. Every
// drain done flips the current epoch and runs the same clearing pass again
// before the next request is taken.
module log_replay_last_op_table import lrt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDef
) (
  input logic      clk,
  input logic      rst_n,
  lrt_req_if.sink  in_req,
  lrt_res_if.source out_res
);
`include "log_replay_last_op_table_assert.svh"
  localparam int unsigned AW = $clog2(SLOT_COUNT);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  lrt_request_t   req_r;
  logic [31:0]    hash_r;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic [AW:0]    cursor_r, cursor_nxt;
  logic           epoch_r, epoch_nxt;
  logic           phase_r, phase_nxt;
  logic           out_valid_r;
  lrt_result_t    res_r, res_nxt;
  logic           rd_used;
  logic [81:0]    rd_data;
  logic           wr_en;
  logic           tag_we;
  logic [AW-1:0]  tag_addr, rd_addr;
  logic           tag_val;
  logic [AW-1:0]  clr_r;
  logic           key_hit;

  assign in_req.ready   = (state_r == S_IDLE);
  assign out_res.valid  = out_valid_r;
  assign out_res.data   = res_r;
  assign rd_addr        = pos_r;
  assign key_hit = (rd_data[81:66] == req_r.rec_type) &&
                   (rd_data[65:34] == req_r.obj_id);

  lrt_slot_mem #(.SLOT_COUNT(SLOT_COUNT), .AW(AW)) u_mem (
    .clk(clk), .rd_addr(rd_addr), .rd_used(rd_used), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(pos_r),
    .wr_data({req_r.rec_type, req_r.obj_id, req_r.op_code, req_r.payload_len}),
    .cur_epoch(epoch_r), .epoch_wr_en(tag_we), .epoch_wr_addr(tag_addr),
    .epoch_wr_val(tag_val)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    cursor_nxt = cursor_r;
    epoch_nxt  = epoch_r;
    phase_nxt  = phase_r;
    res_nxt    = res_r;
    wr_en      = 1'b0;
    tag_we     = 1'b0;
    tag_addr   = pos_r;
    tag_val    = epoch_r;
    case (state_r)
      S_CLEAR: begin
        tag_we   = 1'b1;
        tag_addr = clr_r;
        tag_val  = ~epoch_r;
        if (clr_r == AW'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_req.valid) begin
          res_nxt = '0;
          if (in_req.data.func == FN_DRAIN) begin
            if (cursor_r == (AW+1)'(SLOT_COUNT)) begin
              res_nxt.status = ST_DONE;
              state_nxt = S_OUT;
            end else begin
              pos_nxt   = cursor_r[AW-1:0];
              state_nxt = S_DRAIN;
            end
          end else if (in_req.data.op_code == OP_MARKER) begin
            res_nxt.status = ST_MARKER;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        pos_nxt   = hash_r[AW-1:0] ^ AW'(0);
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!rd_used || key_hit) begin
          wr_en  = 1'b1;
          tag_we = !rd_used;
          res_nxt.status     = rd_used ? ST_UPDATED : ST_NEW;
          res_nxt.slot_index = 12'(pos_r);
          state_nxt = S_OUT;
        end else if (cnt_r == (AW+1)'(SLOT_COUNT - 1)) begin
          res_nxt.status = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DRAIN: begin
        // phase 0 issues the read, phase 1 inspects it
        phase_nxt = ~phase_r;
        if (phase_r) begin
          if (rd_used) begin
            res_nxt.status     = ST_DRAINED;
            res_nxt.slot_index = 12'(pos_r);
            {res_nxt.out_type, res_nxt.out_id, res_nxt.out_op, res_nxt.out_len} =
              rd_data;
            cursor_nxt = {1'b0, pos_r} + 1'b1;
            state_nxt  = S_OUT;
          end else if (pos_r == AW'(SLOT_COUNT - 1)) begin
            res_nxt.status = ST_DONE;
            state_nxt = S_OUT;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_res.ready) begin
          if (res_r.status == ST_DONE) begin
            cursor_nxt = '0;
            epoch_nxt  = ~epoch_r;
            // epoch flip empties the table; a tagged-stale slot of the new
            // epoch is rewritten by the clearing pass
            state_nxt  = S_CLEAR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      epoch_r     <= 1'b0;
      phase_r     <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      epoch_r     <= epoch_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= (state_r == S_CLEAR) ? clr_r + 1'b1 : '0;
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

  // datapath registers, hash taken from the accepted request
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    if (in_req.valid && in_req.ready) begin
      req_r  <= in_req.data;
      hash_r <= 32'(in_req.data.rec_type * HashMult) + in_req.data.obj_id;
    end
  end

  `LR_ASSERT_IMP(a_out_only_in_out, out_valid_r, state_r == S_OUT, "result valid off state")
  `LR_ASSERT_IMP(a_no_take_busy, in_req.ready, !out_valid_r, "request taken while busy")
  `LR_ASSERT_NEXT(a_done_resets, out_valid_r && out_res.ready && res_r.status == ST_DONE,
    cursor_r == '0, "cursor not reset after done")
endmodule

// File: dv/lrt_tb_if.sv
`timescale 1ns / 1ps
// no separate interfaces needed beyond the rtl ones; this file holds the
// testbench-side request constants and the scoreboard class
package lrt_tb_pkg;
  import lrt_pkg::*;

  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;
  localparam logic       FN_RECORD = 1'b0;
  localparam int unsigned TABLE_SLOTS = SlotCountDef;

  // mirror of the last-op table plus a queue of expected results
  class last_op_scoreboard;
    bit          used [TABLE_SLOTS];
    logic [15:0] key_type [TABLE_SLOTS];
    logic [31:0] key_id [TABLE_SLOTS];
    logic [1:0]  last_op [TABLE_SLOTS];
    logic [31:0] last_len [TABLE_SLOTS];
    int unsigned cursor;
    lrt_result_t pending_results[$];
    int unsigned errors;

    function new();
      cursor = 0;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int unsigned home_slot(logic [15:0] ty, logic [31:0] id);
      logic [31:0] h;
      h = ty * HashMult + id;
      return h % TABLE_SLOTS;
    endfunction

    // apply one accepted request to the mirror
    function void note_request(lrt_request_t rq);
      lrt_result_t r;
      int unsigned s;
      bit found;
      r = '0;
      found = 0;
      if (rq.func == FN_DRAIN) begin
        for (int unsigned k = cursor; k < TABLE_SLOTS; k++) begin
          if (used[k]) begin
            cursor = k + 1;
            r.status = ST_DRAINED;
            r.slot_index = k[11:0];
            r.out_type = key_type[k];
            r.out_id = key_id[k];
            r.out_op = last_op[k];
            r.out_len = last_len[k];
            found = 1;
            break;
          end
        end
        if (!found) begin
          foreach (used[i]) used[i] = 1'b0;
          cursor = 0;
          r.status = ST_DONE;
        end
      end else if (rq.op_code == OP_MARKER) begin
        r.status = ST_MARKER;
      end else begin
        r.status = ST_FULL;
        for (int unsigned k = 0; k < TABLE_SLOTS; k++) begin
          s = (home_slot(rq.rec_type, rq.obj_id) + k) % TABLE_SLOTS;
          if (!used[s]) begin
            used[s] = 1'b1;
            key_type[s] = rq.rec_type;
            key_id[s] = rq.obj_id;
            r.status = ST_NEW;
          end else if (key_type[s] == rq.rec_type && key_id[s] == rq.obj_id) begin
            r.status = ST_UPDATED;
          end
          if (r.status != ST_FULL) begin
            last_op[s] = rq.op_code;
            last_len[s] = rq.payload_len;
            r.slot_index = s[11:0];
            break;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(lrt_result_t got);
      lrt_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.out_type !== want.out_type || got.out_id !== want.out_id ||
          got.out_op !== want.out_op || got.out_len !== want.out_len) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d idx=%0d ty=%h id=%h op=%0d len=%h",
                   want.status, want.slot_index, want.out_type, want.out_id,
                   want.out_op, want.out_len,
                   " | got st=%0d idx=%0d ty=%h id=%h op=%0d len=%h",
                   got.status, got.slot_index, got.out_type, got.out_id,
                   got.out_op, got.out_len);
      end
    endfunction
  endclass
endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import lrt_pkg::*;
  import lrt_tb_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;

  logic clk;
  logic rst_n;
  longint cycles;

  lrt_req_if in_req ();
  lrt_res_if out_res ();

  log_replay_last_op_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_res(out_res.source)
  );

  last_op_scoreboard table_mirror;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** log_replay_last_op_table: FAILED **");
      $finish;
    end
  end

  // note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) table_mirror.note_request(in_req.data);
    if (rst_n && out_res.valid && out_res.ready) table_mirror.check_result(out_res.data);
  end

  // result side: random stall before each result
  initial begin
    int unsigned wait_n;
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_n = $urandom_range(0, 4);
      @(negedge clk);
      if (wait_n > 0) begin
        out_res.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!out_res.valid);
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(lrt_request_t rq, bit allow_gap);
    int unsigned gap_n;
    gap_n = allow_gap ? $urandom_range(0, 4) : 0;
    if (gap_n > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap_n) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= rq;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  // drop valid after the last request of a burst
  task automatic release_request();
    in_req.valid <= 1'b0;
  endtask

  function automatic lrt_request_t make_record(logic [1:0] op, logic [15:0] ty,
                                               logic [31:0] id, logic [31:0] len);
    lrt_request_t rq;
    rq.func = FN_RECORD;
    rq.op_code = op;
    rq.rec_type = ty;
    rq.obj_id = id;
    rq.payload_len = len;
    return rq;
  endfunction

  function automatic lrt_request_t make_drain();
    lrt_request_t rq;
    rq = lrt_request_t'($bits(lrt_request_t)'({$urandom, $urandom, $urandom}));
    rq.func = FN_DRAIN;
    return rq;
  endfunction

  task automatic wait_results_empty();
    while (table_mirror.pending_results.size() != 0) @(negedge clk);
  endtask

  // drain until done
  task automatic drain_all();
    lrt_request_t rq;
    do begin
      rq = make_drain();
      send_request(rq, 1);
      release_request();
      @(posedge clk);
      wait_results_empty();
    end while (table_mirror.used.sum() with (int'(item)) != 0 || table_mirror.cursor != 0);
  endtask

  initial begin
    lrt_request_t rq;
    logic [15:0] ty_pool [8];
    logic [31:0] id_pool [8];
    int unsigned k;

    table_mirror = new();
    cycles = 0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every op, markers, updates, collisions, drains
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_0000, 32'h0), 0);
    send_request(make_record(OP_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_request(make_record(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 32'h1234_5678), 0);
    send_request(make_record(OP_DELETE, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF), 0);
    send_request(make_record(OP_MARKER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_request(make_record(OP_MARKER, 16'h0000, 32'h0, 32'h0), 0);
    // same home slot: id differs by the table size
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_1000, 32'h5), 0);
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_2000, 32'h6), 0);
    send_request(make_record(OP_UPDATE, 16'h0000, 32'h0000_2000, 32'h7), 0);
    // wrap at the last slot
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_0FFF, 32'h8), 0);
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_1FFF, 32'h9), 0);
    send_request(make_drain(), 0);
    send_request(make_drain(), 0);
    // record during a drain
    send_request(make_record(OP_CREATE, 16'h0000, 32'h0000_0001, 32'hA), 0);
    send_request(make_record(OP_UPDATE, 16'h0001, 32'h0000_0001, 32'hB), 0);
    release_request();
    // sender holds off until all results are in
    @(posedge clk);
    wait_results_empty();
    drain_all();
    // drain of an empty table
    send_request(make_drain(), 0);

    // random: bursts over a small key pool with drains, then drain all
    for (int round = 0; round < 12; round++) begin
      foreach (ty_pool[i]) begin
        ty_pool[i] = 16'($urandom);
        id_pool[i] = $urandom;
      end
      for (int n = 0; n < 40; n++) begin
        k = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
          0: rq = make_record(OP_MARKER, 16'($urandom), $urandom, $urandom);
          1: rq = make_record(2'($urandom), 16'($urandom), $urandom, $urandom);
          2: rq = make_drain();
          3: rq = make_record(2'($urandom_range(1, 3)), 16'h0000,
                              ($urandom_range(0, 3) << 12) | 32'hFFF, $urandom);
          default: rq = make_record(2'($urandom_range(1, 3)), ty_pool[k], id_pool[k],
                                    $urandom);
        endcase
        send_request(rq, $urandom_range(0, 3) != 0);
      end
      drain_all();
    end

    @(posedge clk);
    wait_results_empty();
    repeat (50) @(posedge clk);
    if (table_mirror.errors == 0 && table_mirror.pending_results.size() == 0) begin
      $display("** log_replay_last_op_table: PASSED **");
    end else begin
      $display("** log_replay_last_op_table: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/lrt_pkg.sv
rtl/lrt_if.sv
rtl/lrt_slot_mem.sv
rtl/log_replay_last_op_table.sv
dv/lrt_tb_if.sv
dv/tb.sv
